/* rtl/ppe_pkg.sv */
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the particle pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_KILL  = 2'd2
  } cmd_e;

  // the one command code that does nothing
  localparam logic [1:0] CmdUnused = 2'd3;

  // result kinds
  typedef enum logic [1:0] {
    KIND_SPAWN = 2'd0,
    KIND_LIVE  = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_KILL  = 2'd3
  } kind_e;

  // fixed point constants
  localparam logic signed [16:0] GravityStep = 17'sd41;     // 0.01 in Q4.12
  localparam logic signed [16:0] BounceGain  = 17'sd26214;  // 0.8 in Q1.15
  localparam int unsigned        MaxReports  = 64;

  // one decoded command request
  typedef struct packed {
    cmd_e               op;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic [15:0]        life;
    logic               grav;
    logic [15:0]        drag;
    logic               bounce;
  } cmd_t;

  // one result request
  typedef struct packed {
    kind_e              kind;
    logic [5:0]         slot;
    logic               evicted;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic [15:0]        remaining;
    logic               last;
  } res_t;

  // back end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

endpackage

/* rtl/particle_pool_engine.sv */
// ----------------------------------------------------------------------------
// particle_pool_engine
// Particle slot pool with spawn, tick and kill commands.
// ----------------------------------------------------------------------------
// Usage: commands enter through a queue port (push / full) and results
// leave through a queue port (pop / empty); the oldest result sits on
// the result ports while empty is low. A short command queue parts the
// intake from the slot sequencer, and a four entry result queue parts the
// sequencer from the consumer, so either side may stall on its own.
// Each command walks the slots of the lifetime and body memories:
//   spawn: one read per slot, then a write
//   kill:  one cleared lifetime per cycle
//   tick:  free and expiring slots are read and skipped, and each live
//          slot is scaled through the shared Q1.15 multiplier
// Command code 3 is taken and dropped without a result.
// After reset the lifetime memory is swept to zero; full stays high
// meanwhile. When the result queue fills, the sequencer holds its
// current step until pop frees an entry.
// ----------------------------------------------------------------------------
module particle_pool_engine #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command_i,
  input  logic signed [23:0] spawn_x_i,
  input  logic signed [23:0] spawn_y_i,
  input  logic signed [23:0] spawn_z_i,
  input  logic signed [15:0] speed_x_i,
  input  logic signed [15:0] speed_y_i,
  input  logic signed [15:0] speed_z_i,
  input  logic [15:0]        life_ticks_i,
  input  logic               gravity_on_i,
  input  logic [15:0]        drag_factor_i,
  input  logic               bounce_on_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic [5:0]         slot_o,
  output logic               evicted_o,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic signed [23:0] pos_z_o,
  output logic [15:0]        remaining_o,
  output logic               last_o
);

  logic                cmd_valid, cmd_ready;
  ppe_pkg::cmd_t       cmd;
  logic                res_push, res_full;
  ppe_pkg::res_t       res_in, res_out;
  ppe_pkg::back_stat_t stat;

  // command intake
  ppe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .hold_i       (stat.clearing),
    .command_i    (command_i),
    .spawn_x_i    (spawn_x_i),
    .spawn_y_i    (spawn_y_i),
    .spawn_z_i    (spawn_z_i),
    .speed_x_i    (speed_x_i),
    .speed_y_i    (speed_y_i),
    .speed_z_i    (speed_z_i),
    .life_ticks_i (life_ticks_i),
    .gravity_on_i (gravity_on_i),
    .drag_factor_i(drag_factor_i),
    .bounce_on_i  (bounce_on_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  // slot sequencer
  ppe_back #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full),
    .stat_o     (stat)
  );

  // result queue
  ppe_res_q u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_out)
  );

  assign kind_o      = res_out.kind;
  assign slot_o      = res_out.slot;
  assign evicted_o   = res_out.evicted;
  assign pos_x_o     = res_out.px;
  assign pos_y_o     = res_out.py;
  assign pos_z_o     = res_out.pz;
  assign remaining_o = res_out.remaining;
  assign last_o      = res_out.last;

`ifndef SYNTHESIS
  // no request is taken while the lifetime memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat.clearing |-> full)
    else $error("command taken during clearing sweep");

  // the sequencer never pushes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed while queue full");

  // a command is only pulled while the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd_valid && cmd_ready) |-> stat.idle)
    else $error("command pulled while busy");

  // a kill acknowledge is always final and carries no slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && kind_o == ppe_pkg::KIND_KILL) |-> (last_o && slot_o == 6'd0))
    else $error("malformed kill acknowledge");
`endif

endmodule

/* rtl/ppe_front.sv */
// ----------------------------------------------------------------------------
// ppe_front
// Accepts command requests, drops the unused code and queues the rest.
// ----------------------------------------------------------------------------
module ppe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                hold_i,
  input  logic [1:0]          command_i,
  input  logic signed [23:0]  spawn_x_i,
  input  logic signed [23:0]  spawn_y_i,
  input  logic signed [23:0]  spawn_z_i,
  input  logic signed [15:0]  speed_x_i,
  input  logic signed [15:0]  speed_y_i,
  input  logic signed [15:0]  speed_z_i,
  input  logic [15:0]         life_ticks_i,
  input  logic                gravity_on_i,
  input  logic [15:0]         drag_factor_i,
  input  logic                bounce_on_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output ppe_pkg::cmd_t       cmd_o
);

  ppe_pkg::cmd_t ent_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          accept, store, take;
  ppe_pkg::cmd_t req;

  // pack the request
  always_comb begin
    req.op     = ppe_pkg::cmd_e'(command_i);
    req.px     = spawn_x_i;
    req.py     = spawn_y_i;
    req.pz     = spawn_z_i;
    req.vx     = speed_x_i;
    req.vy     = speed_y_i;
    req.vz     = speed_z_i;
    req.life   = life_ticks_i;
    req.grav   = gravity_on_i;
    req.drag   = drag_factor_i;
    req.bounce = bounce_on_i;
  end

  // handshake and classification
  assign full_o      = (cnt_q == 2'd2) || hold_i;
  assign accept      = push_i && !full_o;
  assign store       = accept && (command_i != ppe_pkg::CmdUnused);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign take        = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = ent_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (store) begin
      ent_q[wp_q] <= req;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (store) wp_q <= ~wp_q;
      if (take)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, store} - {1'b0, take};
    end
  end

endmodule

/* rtl/ppe_res_q.sv */
// ----------------------------------------------------------------------------
// ppe_res_q
// Small result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module ppe_res_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppe_pkg::res_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ppe_pkg::res_t data_o
);

  ppe_pkg::res_t ent_q [4];
  logic [1:0]    wp_q, rp_q;
  logic [2:0]    cnt_q;
  logic          wr, rd;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = ent_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q[wp_q] <= data_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
    end
  end

endmodule

/* rtl/ppe_back.sv */
// ----------------------------------------------------------------------------
// ppe_back
// Slot sequencer: spawn search, per slot tick update and pool clearing.
// ----------------------------------------------------------------------------
module ppe_back #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  ppe_pkg::cmd_t       cmd_i,
  output logic                res_push_o,
  output ppe_pkg::res_t       res_o,
  input  logic                res_full_i,
  output ppe_pkg::back_stat_t stat_o
);

  localparam int unsigned IW = $clog2(POOL_SLOTS);
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] CntEnd  = CW'(POOL_SLOTS);
  localparam logic [IW-1:0] IdxLast = IW'(POOL_SLOTS - 1);

  // sequencer states
  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_SP_SCAN = 4'd2;
  localparam logic [3:0] ST_SP_WR   = 4'd3;
  localparam logic [3:0] ST_KL_CLR  = 4'd4;
  localparam logic [3:0] ST_KL_ACK  = 4'd5;
  localparam logic [3:0] ST_TK_RD   = 4'd6;
  localparam logic [3:0] ST_TK_CHK  = 4'd7;
  localparam logic [3:0] ST_TK_DX   = 4'd8;
  localparam logic [3:0] ST_TK_DY   = 4'd9;
  localparam logic [3:0] ST_TK_DZ   = 4'd10;
  localparam logic [3:0] ST_TK_MV   = 4'd11;
  localparam logic [3:0] ST_TK_BY   = 4'd12;
  localparam logic [3:0] ST_TK_BX   = 4'd13;
  localparam logic [3:0] ST_TK_WB   = 4'd14;
  localparam logic [3:0] ST_TK_END  = 4'd15;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic [15:0]        drag;
    logic               grav;
    logic               bounce;
  } body_t;

  // saturating Q1.15 scale, round half up
  function automatic logic signed [15:0] scale_q15(input logic signed [16:0] v,
                                                   input logic signed [16:0] g);
    logic signed [33:0] prod;
    logic signed [18:0] shr;
    prod = 34'(v) * 34'(g) + 34'sd16384;
    shr  = prod[33:15];
    if (shr > 19'sd32767)       scale_q15 = 16'sh7fff;
    else if (shr < -19'sd32768) scale_q15 = 16'sh8000;
    else                        scale_q15 = shr[15:0];
  endfunction

  // position plus half velocity, saturated
  function automatic logic signed [23:0] move(input logic signed [23:0] p,
                                              input logic signed [15:0] v);
    logic signed [16:0] v1;
    logic signed [24:0] s;
    v1 = 17'(v) + 17'sd1;
    s  = 25'(p) + 25'(v1 >>> 1);
    if (s > 25'sd8388607)       move = 24'sh7fffff;
    else if (s < -25'sd8388608) move = 24'sh800000;
    else                        move = s[23:0];
  endfunction

  // low six bits of a slot index
  function automatic logic [5:0] slot6(input logic [IW-1:0] i);
    logic [IW+5:0] e;
    e = {6'd0, i};
    slot6 = e[5:0];
  endfunction

  // memories
  logic [15:0] life_mem [POOL_SLOTS];
  body_t       body_mem [POOL_SLOTS];
  logic [15:0] life_rd_q;
  body_t       body_rd_q;
  logic        life_we, body_we;
  logic [IW-1:0] life_wa, body_wa, rd_addr;
  logic [15:0] life_wd;
  body_t       body_wd;

  // control and work registers
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  ppe_pkg::cmd_t cmd_q, cmd_d;
  logic          pv_q, pv_d;
  logic          found_q, found_d;
  logic [IW-1:0] free_q, free_d, min_q, min_d;
  logic [16:0]   best_q, best_d;
  body_t         wk_q, wk_d;
  logic [15:0]   ln_q, ln_d;
  ppe_pkg::res_t pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  logic [6:0]    rep_q, rep_d;

  // shared multiplier operands
  logic signed [16:0] mul_a, mul_b;
  logic signed [15:0] scaled;
  logic signed [15:0] vy_g;
  logic signed [16:0] vy_m;
  logic [IW-1:0]      pick;
  ppe_pkg::res_t      live_res;

  assign scaled = scale_q15(mul_a, mul_b);
  assign pick   = found_q ? free_q : min_q;

  // gravity step on vy
  always_comb begin
    vy_m = 17'(wk_q.vy) - ppe_pkg::GravityStep;
    if (!wk_q.grav)              vy_g = wk_q.vy;
    else if (vy_m < -17'sd32768) vy_g = 16'sh8000;
    else                         vy_g = vy_m[15:0];
  end

  // report of the slot in work
  always_comb begin
    live_res.kind      = ppe_pkg::KIND_LIVE;
    live_res.slot      = slot6(idx_q);
    live_res.evicted   = 1'b0;
    live_res.px        = wk_q.px;
    live_res.py        = wk_q.py;
    live_res.pz        = wk_q.pz;
    live_res.remaining = ln_q;
    live_res.last      = 1'b0;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    cmd_d    = cmd_q;
    pv_d     = 1'b0;
    found_d  = found_q;
    free_d   = free_q;
    min_d    = min_q;
    best_d   = best_q;
    wk_d     = wk_q;
    ln_d     = ln_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    rep_d    = rep_q;

    cmd_ready_o = 1'b0;
    res_push_o  = 1'b0;
    res_o       = pend_q;
    life_we     = 1'b0;
    life_wa     = cnt_q[IW-1:0];
    life_wd     = 16'd0;
    body_we     = 1'b0;
    body_wa     = idx_q;
    body_wd     = wk_q;
    rd_addr     = cnt_q[IW-1:0];
    mul_a       = 17'(wk_q.vx);
    mul_b       = {1'b0, wk_q.drag};

    unique case (state_q)
      ST_CLR: begin
        life_we = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        if (cnt_q[IW-1:0] == IdxLast) state_d = ST_IDLE;
      end

      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          cnt_d    = '0;
          found_d  = 1'b0;
          best_d   = 17'h10000;
          pend_v_d = 1'b0;
          rep_d    = 7'd0;
          unique case (cmd_i.op)
            ppe_pkg::CMD_SPAWN: state_d = ST_SP_SCAN;
            ppe_pkg::CMD_TICK:  state_d = ST_TK_RD;
            ppe_pkg::CMD_KILL:  state_d = ST_KL_CLR;
            default:            state_d = ST_IDLE;
          endcase
        end
      end

      // pipelined scan: issue one read, examine the previous one
      ST_SP_SCAN: begin
        if (cnt_q != CntEnd) begin
          pv_d  = 1'b1;
          idx_d = cnt_q[IW-1:0];
          cnt_d = cnt_q + CW'(1);
        end
        if (pv_q) begin
          if (life_rd_q == 16'd0 && !found_q) begin
            found_d = 1'b1;
            free_d  = idx_q;
          end
          if ({1'b0, life_rd_q} <= best_q) begin
            best_d = {1'b0, life_rd_q};
            min_d  = idx_q;
          end
        end
        if (cnt_q == CntEnd && !pv_q) state_d = ST_SP_WR;
      end

      ST_SP_WR: begin
        res_o.kind      = ppe_pkg::KIND_SPAWN;
        res_o.slot      = slot6(pick);
        res_o.evicted   = !found_q;
        res_o.px        = cmd_q.px;
        res_o.py        = cmd_q.py;
        res_o.pz        = cmd_q.pz;
        res_o.remaining = cmd_q.life;
        res_o.last      = 1'b1;
        body_wa         = pick;
        body_wd.px      = cmd_q.px;
        body_wd.py      = cmd_q.py;
        body_wd.pz      = cmd_q.pz;
        body_wd.vx      = cmd_q.vx;
        body_wd.vy      = cmd_q.vy;
        body_wd.vz      = cmd_q.vz;
        body_wd.drag    = cmd_q.drag;
        body_wd.grav    = cmd_q.grav;
        body_wd.bounce  = cmd_q.bounce;
        life_wa         = pick;
        life_wd         = cmd_q.life;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          life_we    = 1'b1;
          body_we    = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_KL_CLR: begin
        life_we = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        if (cnt_q[IW-1:0] == IdxLast) state_d = ST_KL_ACK;
      end

      ST_KL_ACK: begin
        res_o.kind      = ppe_pkg::KIND_KILL;
        res_o.slot      = 6'd0;
        res_o.evicted   = 1'b0;
        res_o.px        = '0;
        res_o.py        = '0;
        res_o.pz        = '0;
        res_o.remaining = 16'd0;
        res_o.last      = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_TK_RD: begin
        if (cnt_q != CntEnd) begin
          idx_d   = cnt_q[IW-1:0];
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_TK_CHK;
        end else begin
          state_d = ST_TK_END;
        end
      end

      // count down; dead or expiring slots are skipped
      ST_TK_CHK: begin
        ln_d    = life_rd_q - 16'd1;
        wk_d    = body_rd_q;
        life_wa = idx_q;
        life_wd = life_rd_q - 16'd1;
        if (life_rd_q == 16'd0) begin
          state_d = ST_TK_RD;
        end else begin
          life_we = 1'b1;
          state_d = (life_rd_q == 16'd1) ? ST_TK_RD : ST_TK_DX;
        end
      end

      ST_TK_DX: begin
        mul_a   = 17'(wk_q.vx);
        wk_d.vx = scaled;
        state_d = ST_TK_DY;
      end

      ST_TK_DY: begin
        mul_a   = 17'(wk_q.vy);
        wk_d.vy = scaled;
        state_d = ST_TK_DZ;
      end

      ST_TK_DZ: begin
        mul_a   = 17'(wk_q.vz);
        wk_d.vz = scaled;
        state_d = ST_TK_MV;
      end

      ST_TK_MV: begin
        wk_d.vy = vy_g;
        wk_d.px = move(wk_q.px, wk_q.vx);
        wk_d.py = move(wk_q.py, vy_g);
        wk_d.pz = move(wk_q.pz, wk_q.vz);
        state_d = ST_TK_BY;
      end

      // ground bounce on y
      ST_TK_BY: begin
        mul_a = -17'(wk_q.vy);
        mul_b = ppe_pkg::BounceGain;
        if (wk_q.bounce && wk_q.py[23]) begin
          wk_d.py = '0;
          wk_d.vy = scaled;
          state_d = ST_TK_BX;
        end else begin
          state_d = ST_TK_WB;
        end
      end

      ST_TK_BX: begin
        mul_a   = 17'(wk_q.vx);
        mul_b   = ppe_pkg::BounceGain;
        wk_d.vx = scaled;
        state_d = ST_TK_WB;
      end

      // write back; the held report goes out once a later one exists
      ST_TK_WB: begin
        body_we = 1'b1;
        if (rep_q < 7'(ppe_pkg::MaxReports)) begin
          if (!(pend_v_q && res_full_i)) begin
            res_push_o = pend_v_q;
            pend_d     = live_res;
            pend_v_d   = 1'b1;
            rep_d      = rep_q + 7'd1;
            state_d    = ST_TK_RD;
          end
        end else begin
          state_d = ST_TK_RD;
        end
      end

      ST_TK_END: begin
        if (pend_v_q) begin
          res_o.last = 1'b1;
        end else begin
          res_o.kind      = ppe_pkg::KIND_NONE;
          res_o.slot      = 6'd0;
          res_o.evicted   = 1'b0;
          res_o.px        = '0;
          res_o.py        = '0;
          res_o.pz        = '0;
          res_o.remaining = 16'd0;
          res_o.last      = 1'b1;
        end
        if (!res_full_i) begin
          res_push_o = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign stat_o.clearing = (state_q == ST_CLR);
  assign stat_o.idle     = (state_q == ST_IDLE);

  // lifetime memory
  always_ff @(posedge clk_i) begin
    if (life_we) life_mem[life_wa] <= life_wd;
    life_rd_q <= life_mem[rd_addr];
  end

  // particle body memory
  always_ff @(posedge clk_i) begin
    if (body_we) body_mem[body_wa] <= body_wd;
    body_rd_q <= body_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      cnt_q    <= '0;
      pv_q     <= 1'b0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      rep_q    <= 7'd0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pv_q     <= pv_d;
      found_q  <= found_d;
      pend_v_q <= pend_v_d;
      rep_q    <= rep_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cmd_q  <= cmd_d;
    free_q <= free_d;
    min_q  <= min_d;
    best_q <= best_d;
    wk_q   <= wk_d;
    ln_q   <= ln_d;
    pend_q <= pend_d;
  end

endmodule
